// ===== sv/multiset_count_table_assert.svh =====
// Assertion macros shared by the multiset count table modules.
`ifndef MULTISET_COUNT_TABLE_ASSERT_SVH
`define MULTISET_COUNT_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multiset_count_table assertion failed");

// Next-cycle implication, checked outside reset.
`define MCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multiset_count_table assertion failed");

`endif

// ===== sv/mct_pkg.sv =====
// Package for the multiset count table: defaults, codes and control types.
`timescale 1ns / 1ps

package mct_pkg;

  localparam int MCT_ENTRIES    = 16;
  localparam int MCT_KEY_BITS   = 32;
  localparam int MCT_COUNT_BITS = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_t;

endpackage

// ===== sv/mct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mct_ctrl.sv =====
// Controller state machine for the multiset count table.
`timescale 1ns / 1ps
`include "multiset_count_table_assert.svh"

module mct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          scan_done,
  output logic          busy,
  output mct_pkg::ctrl_t ctrl_o
);

  mct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl_o    = '0;
    busy      = 1'b1;
    case (state_r)
      mct_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.load = 1'b1;
          state_nxt   = mct_pkg::S_SCAN;
        end
      end
      mct_pkg::S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (scan_done) begin
          state_nxt = mct_pkg::S_UPDATE;
        end
      end
      mct_pkg::S_UPDATE: begin
        ctrl_o.update = 1'b1;
        state_nxt     = mct_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mct_pkg::S_IDLE;
      end
    endcase
  end

  `MCT_ASSERT_NEXT(a_load_enters_scan, ctrl_o.load, state_r == mct_pkg::S_SCAN && busy)

endmodule

// ===== sv/mct_dp.sv =====
// Datapath of the multiset count table: key/count RAMs, scan pipe, update logic.
`timescale 1ns / 1ps
`include "multiset_count_table_assert.svh"

module mct_dp #(
  parameter int ENTRIES    = mct_pkg::MCT_ENTRIES,
  parameter int KEY_BITS   = mct_pkg::MCT_KEY_BITS,
  parameter int COUNT_BITS = mct_pkg::MCT_COUNT_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mct_pkg::ctrl_t ctrl_i,
  output logic           scan_done,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_key,
  input  logic [15:0]    in_amount,
  output logic           out_valid,
  output logic [15:0]    out_count_now,
  output logic [1:0]     out_status,
  output logic [19:0]    out_total,
  output logic           out_all_single,
  output logic [4:0]     out_used_entries
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int UW  = $clog2(ENTRIES + 1);
  localparam int SW  = COUNT_BITS + UW;
  localparam int TW  = (SW > 20) ? SW : 20;
  localparam int AW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int AW1 = AW + 1;
  localparam int UXW = (UW > 5) ? UW : 5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
  localparam logic [15:0]           NOW_MAX   = 16'hFFFF;
  localparam logic [19:0]           TOTAL_MAX = 20'hFFFFF;
  localparam logic [4:0]            USED_MAX  = 5'd31;

  // transaction registers
  mct_pkg::cmd_t         cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [15:0]           amt_r;

  // scan pipe
  logic [UW-1:0]         idx_r;
  logic                  cmp_vld_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  hit_r;
  logic [IW-1:0]         slot_r;
  logic [COUNT_BITS-1:0] cnt_r;

  // table summary
  logic [UW-1:0]         used_r, used_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [UW-1:0]         multi_r, multi_nxt;

  // result registers
  logic                  out_valid_r;
  logic [15:0]           out_count_r;
  mct_pkg::status_t      out_status_r, status_nxt;
  logic [19:0]           out_total_r;
  logic                  out_single_r;
  logic [4:0]            out_used_r;

  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  match;

  logic                  key_we, cnt_we;
  logic [IW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] old_c, new_c;
  logic [AW-1:0]         old_w, amt_w, diff_w, now_w;
  logic [AW1-1:0]        add_w;
  logic [COUNT_BITS-1:0] add_sat;
  logic                  enough, chg;
  logic [TW-1:0]         tsum;
  logic [UXW-1:0]        tused;

  mct_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (ctrl_i.update && key_we),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (idx_r[IW-1:0]),
    .rdata (key_q)
  );

  mct_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (ctrl_i.update && cnt_we),
    .waddr (wr_addr),
    .wdata (new_c),
    .raddr (idx_r[IW-1:0]),
    .rdata (cnt_q)
  );

  // read of idx_r issued this cycle, data of cmp_idx_r compared this cycle
  assign match     = cmp_vld_r && !hit_r && (key_q == key_r);
  assign scan_done = (cmd_r == mct_pkg::CMD_CLEAR) || match || (idx_r >= used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (ctrl_i.load) begin
      cmd_r     <= mct_pkg::cmd_t'(in_cmd);
      key_r     <= KEY_BITS'(in_key);
      amt_r     <= in_amount;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (ctrl_i.scan) begin
      cmp_vld_r <= (idx_r < used_r);
      cmp_idx_r <= idx_r[IW-1:0];
      if (idx_r < used_r) begin
        idx_r <= idx_r + UW'(1);
      end
      if (match) begin
        hit_r  <= 1'b1;
        slot_r <= cmp_idx_r;
        cnt_r  <= cnt_q;
      end
    end
  end

  // count arithmetic, carried at the wider of the count and amount widths
  assign old_c   = hit_r ? cnt_r : '0;
  assign old_w   = AW'(old_c);
  assign amt_w   = AW'(amt_r);
  assign add_w   = AW1'(old_w) + AW1'(amt_w);
  assign add_sat = (add_w > AW1'(CNT_MAX)) ? CNT_MAX : add_w[COUNT_BITS-1:0];
  assign enough  = (old_w >= amt_w);
  assign diff_w  = old_w - amt_w;

  always_comb begin
    used_nxt   = used_r;
    sum_nxt    = sum_r;
    multi_nxt  = multi_r;
    status_nxt = mct_pkg::ST_OK;
    now_w      = '0;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    wr_addr    = slot_r;
    new_c      = old_c;
    chg        = 1'b0;
    case (cmd_r)
      mct_pkg::CMD_ADD: begin
        if (hit_r) begin
          cnt_we = 1'b1;
          new_c  = add_sat;
          chg    = 1'b1;
          now_w  = AW'(add_sat);
        end else if (used_r < UW'(ENTRIES)) begin
          // new key: old count is zero, so add_sat is the clipped amount
          key_we   = 1'b1;
          cnt_we   = 1'b1;
          wr_addr  = used_r[IW-1:0];
          used_nxt = used_r + UW'(1);
          new_c    = add_sat;
          chg      = 1'b1;
          now_w    = AW'(add_sat);
        end else begin
          status_nxt = mct_pkg::ST_FULL;
        end
      end
      mct_pkg::CMD_REMOVE: begin
        if (enough) begin
          if (hit_r) begin
            cnt_we = 1'b1;
            new_c  = diff_w[COUNT_BITS-1:0];
            chg    = 1'b1;
          end
          now_w = diff_w;
        end else begin
          status_nxt = mct_pkg::ST_SHORT;
          now_w      = old_w;
        end
      end
      mct_pkg::CMD_QUERY: begin
        now_w      = old_w;
        status_nxt = enough ? mct_pkg::ST_OK : mct_pkg::ST_SHORT;
      end
      mct_pkg::CMD_CLEAR: begin
        used_nxt  = '0;
        sum_nxt   = '0;
        multi_nxt = '0;
      end
      default: begin
        status_nxt = mct_pkg::ST_OK;
      end
    endcase
    if (chg) begin
      sum_nxt   = sum_r - SW'(old_c) + SW'(new_c);
      multi_nxt = multi_r - UW'(old_c > CNT_ONE) + UW'(new_c > CNT_ONE);
    end
  end

  assign tsum  = TW'(sum_nxt);
  assign tused = UXW'(used_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      sum_r       <= '0;
      multi_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl_i.update;
      if (ctrl_i.update) begin
        used_r       <= used_nxt;
        sum_r        <= sum_nxt;
        multi_r      <= multi_nxt;
        out_status_r <= status_nxt;
        out_count_r  <= (now_w > AW'(NOW_MAX)) ? NOW_MAX : now_w[15:0];
        out_total_r  <= (tsum > TW'(TOTAL_MAX)) ? TOTAL_MAX : tsum[19:0];
        out_used_r   <= (tused > UXW'(USED_MAX)) ? USED_MAX : tused[4:0];
        out_single_r <= (multi_nxt == '0);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count_now    = out_count_r;
  assign out_status       = out_status_r;
  assign out_total        = out_total_r;
  assign out_all_single   = out_single_r;
  assign out_used_entries = out_used_r;

  `MCT_ASSERT_NOW(a_used_bound, 1'b1, used_r <= UW'(ENTRIES))
  `MCT_ASSERT_NOW(a_multi_bound, 1'b1, multi_r <= used_r)
  `MCT_ASSERT_NOW(a_full_flag, out_valid_r && out_status_r == mct_pkg::ST_FULL, used_r == UW'(ENTRIES))
  `MCT_ASSERT_NOW(a_hit_slot, hit_r, UW'(slot_r) < used_r)

endmodule

// ===== sv/multiset_count_table.sv =====
// Top level of the multiset count table: controller plus datapath.
// A start is taken whenever busy is low. The block then scans its stored keys one per
// cycle through the key RAM's single read port until a match or the end of the used
// entries (a clear ends the scan at once), then updates; no new item is taken while busy.
// The result appears on the out_ ports for exactly one cycle, marked by out_valid, in
// the cycle busy drops; a new start may be taken in that same cycle. The receiver
// cannot stall, so out_valid must be sampled every cycle. Entries whose count falls
// to zero stay in the table until a clear.
`timescale 1ns / 1ps

module multiset_count_table #(
  parameter int ENTRIES    = mct_pkg::MCT_ENTRIES,
  parameter int KEY_BITS   = mct_pkg::MCT_KEY_BITS,
  parameter int COUNT_BITS = mct_pkg::MCT_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [15:0] in_amount,
  output logic        out_valid,
  output logic [15:0] out_count_now,
  output logic [1:0]  out_status,
  output logic [19:0] out_total,
  output logic        out_all_single,
  output logic [4:0]  out_used_entries
);

  mct_pkg::ctrl_t ctrl;
  logic           scan_done;

  mct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .scan_done (scan_done),
    .busy      (busy),
    .ctrl_o    (ctrl)
  );

  mct_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl_i           (ctrl),
    .scan_done        (scan_done),
    .in_cmd           (in_cmd),
    .in_key           (in_key),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_count_now    (out_count_now),
    .out_status       (out_status),
    .out_total        (out_total),
    .out_all_single   (out_all_single),
    .out_used_entries (out_used_entries)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the multiset count table: directed corners plus random traffic.
`timescale 1ns / 1ps

module testbench;
  import mct_pkg::*;

  localparam int          TABLE_DEPTH  = MCT_ENTRIES;
  localparam logic [16:0] COUNT_TOP    = 17'h0FFFF;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          POOL_SIZE    = 24;
  localparam int          PRINT_CAP    = 100;

  typedef struct {
    logic [15:0] count_now;
    status_t     status;
    logic [19:0] total;
    logic        all_single;
    logic [4:0]  used_entries;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  cmd_t        in_cmd = CMD_QUERY;
  logic [31:0] in_key = '0;
  logic [15:0] in_amount = '0;
  logic        busy;
  logic        out_valid;
  logic [15:0] out_count_now;
  logic [1:0]  out_status;
  logic [19:0] out_total;
  logic        out_all_single;
  logic [4:0]  out_used_entries;

  // Mirror of the table contents
  logic [31:0] key_mirror [TABLE_DEPTH];
  logic [15:0] count_mirror [TABLE_DEPTH];
  logic [4:0]  mirror_used = '0;
  logic [19:0] mirror_sum = '0;
  logic [4:0]  mirror_multi = '0;

  tally_t      expected_tallies [$];
  logic [31:0] key_pool [POOL_SIZE];

  int sender_idle_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int saturated_adds = 0;
  int short_replies = 0;
  int clears_sent = 0;
  int cycle_count = 0;

  multiset_count_table DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_key           (in_key),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_count_now    (out_count_now),
    .out_status       (out_status),
    .out_total        (out_total),
    .out_all_single   (out_all_single),
    .out_used_entries (out_used_entries)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < mirror_used && key_mirror[i] == k) return i;
    end
    return -1;
  endfunction

  // Keeps the running sum and the count of multi-entries in step with the table.
  function automatic void set_mirror_count(int idx, logic [15:0] c);
    if (count_mirror[idx] > 16'd1) mirror_multi = mirror_multi - 5'd1;
    if (c > 16'd1) mirror_multi = mirror_multi + 5'd1;
    mirror_sum = mirror_sum - 20'(count_mirror[idx]) + 20'(c);
    count_mirror[idx] = c;
  endfunction

  function automatic tally_t apply_op(cmd_t c, logic [31:0] k, logic [15:0] a);
    tally_t      t;
    int          idx;
    logic [16:0] wide;
    logic [15:0] held;
    t.count_now = '0;
    t.status = ST_OK;
    idx = find_key(k);
    held = (idx >= 0) ? count_mirror[idx] : 16'd0;
    case (c)
      CMD_ADD: begin
        if (idx >= 0) begin
          wide = {1'b0, held} + {1'b0, a};
          if (wide > COUNT_TOP) begin
            wide = COUNT_TOP;
            saturated_adds++;
          end
          set_mirror_count(idx, wide[15:0]);
          t.count_now = wide[15:0];
        end else if (mirror_used < TABLE_DEPTH) begin
          idx = mirror_used;
          key_mirror[idx] = k;
          count_mirror[idx] = '0;
          mirror_used = mirror_used + 5'd1;
          set_mirror_count(idx, a);
          t.count_now = a;
        end else begin
          t.status = ST_FULL;
          full_refusals++;
        end
      end
      CMD_REMOVE: begin
        if (held >= a) begin
          if (idx >= 0) set_mirror_count(idx, held - a);
          t.count_now = held - a;
        end else begin
          t.status = ST_SHORT;
          t.count_now = held;
          short_replies++;
        end
      end
      CMD_QUERY: begin
        t.count_now = held;
        if (held < a) begin
          t.status = ST_SHORT;
          short_replies++;
        end
      end
      default: begin
        // clear: stored keys stay but nothing below the used mark is left
        mirror_used = '0;
        mirror_sum = '0;
        mirror_multi = '0;
        clears_sent++;
      end
    endcase
    t.total = mirror_sum;
    t.all_single = (mirror_multi == 5'd0);
    t.used_entries = mirror_used;
    return t;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    // cap the log on a badly broken block; every mismatch is still counted
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0d, expected %0d (result %0d)", field, got, want,
               results_checked);
    mismatches++;
  endtask

  // One transaction: random hold-off, then hold start until busy is low at an edge.
  task automatic issue_op(cmd_t c, logic [31:0] k, logic [15:0] a);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_key <= k;
    in_amount <= a;
    do @(posedge clk); while (busy);
    expected_tallies.push_back(apply_op(c, k, a));
    items_sent++;
  endtask

  always @(posedge clk) begin : check_results
    tally_t want;
    if (rst_n && out_valid) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_tallies.pop_front();
        if (out_count_now !== want.count_now)
          report_mismatch("count_now", out_count_now, want.count_now);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_total !== want.total)
          report_mismatch("total", out_total, want.total);
        if (out_all_single !== want.all_single)
          report_mismatch("all_single", out_all_single, want.all_single);
        if (out_used_entries !== want.used_entries)
          report_mismatch("used_entries", out_used_entries, want.used_entries);
      end
      results_checked++;
    end
  end

  task automatic test_empty_table();
    issue_op(CMD_CLEAR, 32'h0, 16'h0);
    issue_op(CMD_QUERY, 32'h0, 16'h0);
    issue_op(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0);
    issue_op(CMD_REMOVE, 32'hFFFF_FFFF, 16'h1);
    // new key with zero amount still claims an entry
    issue_op(CMD_ADD, 32'h0, 16'h0);
  endtask

  task automatic test_count_limits();
    issue_op(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(CMD_ADD, 32'hFFFF_FFFF, 16'h1);
    issue_op(CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(CMD_REMOVE, 32'hFFFF_FFFF, 16'h1);
    issue_op(CMD_QUERY, 32'hFFFF_FFFF, 16'h1);
  endtask

  task automatic test_full_table();
    for (int i = 1; i <= TABLE_DEPTH - 2; i++)
      issue_op(CMD_ADD, 32'(i) * 32'h1111_1111, 16'h1);
    issue_op(CMD_ADD, 32'h5A5A_5A5A, 16'h2);
    issue_op(CMD_CLEAR, 32'hA5A5_A5A5, 16'hFFFF);
  endtask

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(3));
      5, 6:          return 16'($urandom_range(300));
      7:             return 16'($urandom);
      8:             return 16'hFFFF;
      default:       return 16'h0;
    endcase
  endfunction

  // Mostly keys from a small pool so hits, zero counts and a full table are common.
  task automatic test_random_traffic(int n, int idle_pct);
    int          r;
    cmd_t        c;
    logic [31:0] k;
    sender_idle_pct = idle_pct;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)      c = CMD_ADD;
      else if (r < 70) c = CMD_REMOVE;
      else if (r < 97) c = CMD_QUERY;
      else             c = CMD_CLEAR;
      k = ($urandom_range(3) == 0) ? 32'($urandom) : key_pool[$urandom_range(POOL_SIZE - 1)];
      issue_op(c, k, pick_amount());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 31;
    test_empty_table();
    test_count_limits();
    test_full_table();
    test_random_traffic(650, 31);
    test_random_traffic(650, 47);
    test_random_traffic(650, 0);
    start <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d transactions (%0d clears), checked %0d results", items_sent,
             clears_sent, results_checked);
    $display("table full: %0d, saturated adds: %0d, short replies: %0d, mismatches: %0d",
             full_refusals, saturated_adds, short_replies, mismatches);
    if (mismatches == 0 && expected_tallies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             expected_tallies.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mct_pkg.sv
sv/mct_ram.sv
sv/mct_ctrl.sv
sv/mct_dp.sv
sv/multiset_count_table.sv
tb/testbench.sv
